@@ hdl/sgtb_pkg.sv @@
package sgtb_pkg;

    // function codes on the input tuser
    typedef enum logic [1:0] {
        OP_TAP   = 2'd0,
        OP_PIXEL = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TILE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_KERNEL_RADIUS = 2'd2;

    localparam int ACC_W = 32;

    // one decoded item between front and back
    typedef struct packed {
        op_t         op;
        logic [5:0]  tap_index;
        logic [15:0] tap_weight;
        logic [23:0] rgb;        // red in the high byte
    } item_t;

    // round half up to integer, saturate to 0..255
    function automatic logic [7:0] finish_channel(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] v;
        begin
            v = ({1'b0, acc} + (ACC_W+1)'(32'h8000)) >> 16;
            finish_channel = (v > (ACC_W+1)'(255)) ? 8'hff : v[7:0];
        end
    endfunction

endpackage

@@ hdl/sgtb_fifo.sv @@
module sgtb_fifo
    import sgtb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && not_empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && not_empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && not_empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/sgtb_front.sv @@
module sgtb_front
    import sgtb_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        queue_full,
    output logic        push,
    output item_t       push_item
);

    // unused function code is accepted and dropped
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full && (s_tuser != FUNC_UNUSED);

    always_comb
    begin
        push_item.op         = op_t'(s_tuser);
        push_item.tap_index  = s_tdata[5:0];
        push_item.tap_weight = s_tdata[21:6];
        push_item.rgb        = {s_tdata[29:22], s_tdata[37:30], s_tdata[45:38]};
    end

endmodule

@@ hdl/sgtb_engine.sv @@
module sgtb_engine
    import sgtb_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_TAPS   = 50,
    parameter int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int TW = $clog2(MAX_TAPS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  item_t         item,
    output logic          item_pop,
    input  logic [WW-1:0] eff_w,
    input  logic [HW-1:0] eff_h,
    input  logic [TW-1:0] eff_r,
    input  logic [CW-1:0] total,
    input  logic          clear_tile,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DW = (WW > HW) ? WW : HW;
    localparam int SW = ((DW > TW) ? DW : TW) + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BURST,
        ST_DRAIN,
        ST_READ
    } state_t;

    state_t state_reg;

    logic [23:0] src_mem  [CELLS];
    logic [23:0] rowp_mem [CELLS];
    logic [23:0] blur_mem [CELLS];
    logic [15:0] tap_mem  [MAX_TAPS+1];

    logic [CW-1:0] load_count_reg;
    logic [CW-1:0] read_count_reg;
    logic          ready_reg;

    logic [DW-1:0]        x_reg, y_reg;
    logic signed [SW-1:0] k_reg;
    logic [AW-1:0]        base_reg;
    logic                 pass_reg;   // 0 horizontal, 1 vertical
    logic [1:0]           drain_reg;

    logic          out_valid_reg;
    logic [7:0]    out_r_reg, out_g_reg, out_b_reg;
    logic          out_last_reg, out_status_reg;

    // sequencer address generation
    logic signed [SW-1:0] pos, lim, p, pc, r_s;
    logic [DW-1:0]        pcu;
    logic [AW-1:0]        rd_addr, dst_addr;
    logic [TW-1:0]        tap_addr;
    logic                 issue, k_last;

    // pipeline
    logic          s1_valid_reg, s1_first_reg, s1_last_reg, s1_pass_reg;
    logic [AW-1:0] s1_dst_reg;
    logic [23:0]   src_q_reg, rowp_q_reg, blur_q_reg;
    logic [15:0]   tap_q_reg;
    logic [23:0]   s1_pix;
    logic          s2_valid_reg, s2_first_reg, s2_last_reg, s2_pass_reg;
    logic [AW-1:0] s2_dst_reg;
    logic [23:0]   prod_r_reg, prod_g_reg, prod_b_reg;
    logic [ACC_W-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [ACC_W-1:0] sum_r, sum_g, sum_b;
    logic [23:0]   done_pix;

    // item handling
    logic [CW-1:0] lc_eff, lc_new;
    logic          tap_we, src_we;

    assign r_s    = SW'($signed({1'b0, eff_r}));
    assign pos    = pass_reg ? SW'($signed({1'b0, y_reg})) : SW'($signed({1'b0, x_reg}));
    assign lim    = pass_reg ? SW'($signed({1'b0, eff_h})) - SW'(1)
                             : SW'($signed({1'b0, eff_w})) - SW'(1);
    assign p      = pos + k_reg;
    assign pc     = (p < 0) ? '0 : ((p > lim) ? lim : p);
    assign pcu    = pc[DW-1:0];
    assign rd_addr = pass_reg ? AW'(AW'(pcu) * AW'(eff_w) + AW'(x_reg))
                              : AW'(base_reg + AW'(pcu));
    assign dst_addr = AW'(base_reg + AW'(x_reg));
    assign tap_addr = (k_reg < 0) ? TW'(-k_reg) : TW'(k_reg);
    assign k_last   = (k_reg == r_s);
    assign issue    = (state_reg == ST_BURST);

    assign lc_eff = ready_reg ? '0 : load_count_reg;
    assign lc_new = (lc_eff < total) ? lc_eff + 1'b1 : lc_eff;

    assign item_pop = item_valid && (state_reg == ST_IDLE)
                      && ((item.op != OP_READ) || !out_valid_reg);
    assign tap_we = item_pop && (item.op == OP_TAP)
                    && (32'(item.tap_index) <= MAX_TAPS);
    assign src_we = item_pop && (item.op == OP_PIXEL) && (lc_eff < total);

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[TW'(item.tap_index)] <= item.tap_weight;
        end
        tap_q_reg <= tap_mem[tap_addr];
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[AW'(lc_eff)] <= item.rgb;
        end
        src_q_reg <= src_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_last_reg && !s2_pass_reg)
        begin
            rowp_mem[s2_dst_reg] <= done_pix;
        end
        rowp_q_reg <= rowp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_last_reg && s2_pass_reg)
        begin
            blur_mem[s2_dst_reg] <= done_pix;
        end
        blur_q_reg <= blur_mem[AW'(read_count_reg)];
    end

    // multiply and accumulate
    assign s1_pix = s1_pass_reg ? rowp_q_reg : src_q_reg;
    assign sum_r  = (s2_first_reg ? '0 : acc_r_reg) + ACC_W'(prod_r_reg);
    assign sum_g  = (s2_first_reg ? '0 : acc_g_reg) + ACC_W'(prod_g_reg);
    assign sum_b  = (s2_first_reg ? '0 : acc_b_reg) + ACC_W'(prod_b_reg);
    assign done_pix = {finish_channel(sum_r), finish_channel(sum_g), finish_channel(sum_b)};

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == -r_s);
        s1_last_reg  <= k_last;
        s1_pass_reg  <= pass_reg;
        s1_dst_reg   <= dst_addr;
        prod_r_reg   <= 24'(s1_pix[23:16]) * 24'(tap_q_reg);
        prod_g_reg   <= 24'(s1_pix[15:8]) * 24'(tap_q_reg);
        prod_b_reg   <= 24'(s1_pix[7:0]) * 24'(tap_q_reg);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_pass_reg  <= s1_pass_reg;
        s2_dst_reg   <= s1_dst_reg;
        if (s2_valid_reg)
        begin
            acc_r_reg <= sum_r;
            acc_g_reg <= sum_g;
            acc_b_reg <= sum_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            read_count_reg <= '0;
            ready_reg      <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            k_reg          <= '0;
            base_reg       <= '0;
            pass_reg       <= 1'b0;
            drain_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_r_reg      <= '0;
            out_g_reg      <= '0;
            out_b_reg      <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_tile)
            begin
                load_count_reg <= '0;
                read_count_reg <= '0;
                ready_reg      <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_pop)
                    begin
                        case (item.op)
                            OP_PIXEL:
                            begin
                                ready_reg      <= 1'b0;
                                load_count_reg <= lc_new;
                                if (ready_reg)
                                begin
                                    read_count_reg <= '0;
                                end
                                if (lc_new >= total)
                                begin
                                    state_reg <= ST_BURST;
                                    pass_reg  <= 1'b0;
                                    x_reg     <= '0;
                                    y_reg     <= '0;
                                    base_reg  <= '0;
                                    k_reg     <= -r_s;
                                end
                            end
                            OP_READ:
                            begin
                                if (ready_reg)
                                begin
                                    state_reg <= ST_READ;
                                end
                                else
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_r_reg      <= '0;
                                    out_g_reg      <= '0;
                                    out_b_reg      <= '0;
                                    out_last_reg   <= 1'b0;
                                    out_status_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_BURST:
                begin
                    if (!k_last)
                    begin
                        k_reg <= k_reg + SW'(1);
                    end
                    else
                    begin
                        k_reg <= -r_s;
                        if (x_reg != DW'(eff_w - 1'b1))
                        begin
                            x_reg <= x_reg + 1'b1;
                        end
                        else
                        begin
                            x_reg <= '0;
                            if (y_reg != DW'(eff_h - 1'b1))
                            begin
                                y_reg    <= y_reg + 1'b1;
                                base_reg <= base_reg + AW'(eff_w);
                            end
                            else
                            begin
                                y_reg     <= '0;
                                base_reg  <= '0;
                                drain_reg <= 2'd2;
                                state_reg <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_reg != '0)
                    begin
                        drain_reg <= drain_reg - 1'b1;
                    end
                    else if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= ST_BURST;
                    end
                    else
                    begin
                        ready_reg      <= 1'b1;
                        read_count_reg <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    out_valid_reg  <= 1'b1;
                    out_r_reg      <= blur_q_reg[23:16];
                    out_g_reg      <= blur_q_reg[15:8];
                    out_b_reg      <= blur_q_reg[7:0];
                    out_last_reg   <= (read_count_reg + 1'b1 == total);
                    out_status_reg <= 1'b0;
                    read_count_reg <= (read_count_reg + 1'b1 >= total) ? '0
                                                                      : read_count_reg + 1'b1;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_b_reg, out_g_reg, out_r_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ hdl/separable_gaussian_tile_blur_top.sv @@
// a tap or pixel load is registered in the queue and written to its memory when the engine
// pops it; a read word passes the queue and, for a ready tile, the read state and output register
// the pixel that fills the tile starts a blur burst, a horizontal and then a vertical pass, one
// tap per cycle through the shared multiply-accumulate pipe; items queue meanwhile
// the back end retires one load per cycle outside a burst; a read waits for the output to drain
// reset: control state clears at once; tap and tile memories are undefined until written
module separable_gaussian_tile_blur_top
    import sgtb_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_TAPS   = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tap_index, tap_weight, red, green, blue
    input  logic [1:0]  s_tuser,   // func
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast,   // last_pixel
    output logic        m_tuser    // status
);

    localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int TW = $clog2(MAX_TAPS + 1);

    // raw register values
    logic [6:0] tile_width_reg;
    logic [6:0] tile_height_reg;
    logic [5:0] kernel_radius_reg;

    // clamped sizes and tile cell count
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [TW-1:0] eff_r;
    logic [CW-1:0] total_reg;
    logic          clear_tile;

    // front to back queue
    logic  push, queue_full, pop, not_empty;
    item_t push_item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg    <= 7'd64;
            tile_height_reg   <= 7'd64;
            kernel_radius_reg <= 6'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TILE_WIDTH:    tile_width_reg    <= cfg_data;
                REG_TILE_HEIGHT:   tile_height_reg   <= cfg_data;
                REG_KERNEL_RADIUS: kernel_radius_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // a size change drops the tile in progress
    assign clear_tile = cfg_we && ((cfg_index == REG_TILE_WIDTH)
                                   || (cfg_index == REG_TILE_HEIGHT));

    assign eff_w = (tile_width_reg == '0) ? WW'(1)
                 : ((32'(tile_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(tile_width_reg));
    assign eff_h = (tile_height_reg == '0) ? HW'(1)
                 : ((32'(tile_height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                        : HW'(tile_height_reg));
    assign eff_r = (kernel_radius_reg == '0) ? TW'(1)
                 : ((32'(kernel_radius_reg) > MAX_TAPS) ? TW'(MAX_TAPS)
                                                        : TW'(kernel_radius_reg));

    // cell count is registered; the user must change config only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= CW'(MAX_WIDTH * MAX_HEIGHT);
        end
        else
        begin
            total_reg <= CW'(eff_w) * CW'(eff_h);
        end
    end

    sgtb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    sgtb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    sgtb_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_TAPS   (MAX_TAPS),
        .CW         (CW),
        .WW         (WW),
        .HW         (HW),
        .TW         (TW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (not_empty),
        .item       (head),
        .item_pop   (pop),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .eff_r      (eff_r),
        .total      (total_reg),
        .clear_tile (clear_tile),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
